### design/rbfi_pkg.sv
// Package: payload types, divider stage record and helpers for the ray/box face unit.
package rbfi_pkg;

   localparam int CW = 32;        // coordinate width
   localparam int QW = CW + 2;    // quotient bits kept by the divider
   localparam int PW = 2 * CW;    // product magnitude width
   localparam int VW = QW + 2;    // width of a crossing coordinate before the bounds test
   localparam int DW = 2 * CW + 3; // width of the dot product sum

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic signed [CW-1:0] origin_x;
      logic signed [CW-1:0] origin_y;
      logic signed [CW-1:0] origin_z;
      logic signed [CW-1:0] heading_x;
      logic signed [CW-1:0] heading_y;
      logic signed [CW-1:0] heading_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] fwd_x;
      logic signed [CW-1:0] fwd_y;
      logic signed [CW-1:0] fwd_z;
      logic signed [CW-1:0] back_x;
      logic signed [CW-1:0] back_y;
      logic signed [CW-1:0] back_z;
      logic [1:0]           hit_mask;
      logic                 excess_hits;
   } rsp_type;

   // One numerator product on its way into the divider
   typedef struct packed {
      logic          neg;
      logic [CW-1:0] dmag;
      logic [PW-1:0] prod;
   } prod_type;

   // One restoring division in flight
   typedef struct packed {
      logic          ovf;
      logic          neg;
      logic [CW-1:0] dmag;
      logic [CW-1:0] rem;
      logic [QW-1:0] num;
      logic [QW-1:0] quo;
   } div_type;

   function automatic coord_type org(input req_type r, input int k);
      coord_type v;
      unique case (k)
         0: v = r.origin_x;
         1: v = r.origin_y;
         default: v = r.origin_z;
      endcase
      return v;
   endfunction

   function automatic coord_type hdg(input req_type r, input int k);
      coord_type v;
      unique case (k)
         0: v = r.heading_x;
         1: v = r.heading_y;
         default: v = r.heading_z;
      endcase
      return v;
   endfunction

   function automatic logic [CW-1:0] cmag(input coord_type x);
      logic [CW-1:0] m;
      m = x[CW-1] ? (~x + 1'b1) : x;
      return m;
   endfunction

   // One quotient bit: shift in the next numerator bit, subtract if it fits
   function automatic div_type div_step(input div_type d);
      div_type        n;
      logic [CW:0]    t;
      n = d;
      t = {d.rem, d.num[QW-1]};
      n.num = {d.num[QW-2:0], 1'b0};
      if (t >= {1'b0, d.dmag}) begin
         n.rem = CW'(t - {1'b0, d.dmag});
         n.quo = {d.quo[QW-2:0], 1'b1};
      end else begin
         n.rem = t[CW-1:0];
         n.quo = {d.quo[QW-2:0], 1'b0};
      end
      return n;
   endfunction

endpackage

### design/ray_box_face_intersection.sv
// Top level: pipelined line against axis-aligned box face intersection.
//
// Usage: a line (origin, heading) in signed fixed point enters on the req_
// channel, one item per cycle at most; the box corners live in six registers
// on the APB-style port (box_min_x/y/z at 0x00..0x08, box_max_x/y/z at
// 0x0C..0x14). Write the box only while no item is in flight.
// Each item yields one result on the rsp_ channel: the forward and backward
// face crossings, a two-bit mask of which were found, and a flag when more
// than two faces were crossed.
// Throughput is one item per cycle while the output is not stalled. The depth is
// set by the bit-serial restoring dividers, one quotient bit per stage over
// 34 stages, plus seven stages of difference, product, range check, bounds
// test, hit selection, dot product and output.
// Reset (synchronous) clears every valid bit and the box registers to zero.
// When rsp_stall is high a valid output holds; bubbles in the pipe still close
// up, and req_stall rises only once every stage is full.
module ray_box_face_intersection (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rbfi_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rbfi_pkg::rsp_type   rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import rbfi_pkg::*;

   localparam logic [2:0] RG_MIN_X = 3'd0;
   localparam logic [2:0] RG_MIN_Y = 3'd1;
   localparam logic [2:0] RG_MIN_Z = 3'd2;
   localparam logic [2:0] RG_MAX_X = 3'd3;
   localparam logic [2:0] RG_MAX_Y = 3'd4;
   localparam logic [2:0] RG_MAX_Z = 3'd5;

   // ---------------- configuration ----------------
   coord_type box_lo_ff [3];
   coord_type box_hi_ff [3];

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            box_lo_ff[k] <= '0;
            box_hi_ff[k] <= '0;
         end
      end else if (psel && penable && pwrite) begin
         unique case (paddr[4:2])
            RG_MIN_X: box_lo_ff[0] <= pwdata;
            RG_MIN_Y: box_lo_ff[1] <= pwdata;
            RG_MIN_Z: box_lo_ff[2] <= pwdata;
            RG_MAX_X: box_hi_ff[0] <= pwdata;
            RG_MAX_Y: box_hi_ff[1] <= pwdata;
            RG_MAX_Z: box_hi_ff[2] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         RG_MIN_X: prdata = box_lo_ff[0];
         RG_MIN_Y: prdata = box_lo_ff[1];
         RG_MIN_Z: prdata = box_lo_ff[2];
         RG_MAX_X: prdata = box_hi_ff[0];
         RG_MAX_Y: prdata = box_hi_ff[1];
         RG_MAX_Z: prdata = box_hi_ff[2];
         default:  prdata = '0;
      endcase
   end

   // face f lies on axis f/2, min face for even f, max face for odd f
   function automatic coord_type face_c(input int f);
      return (f % 2 == 1) ? box_hi_ff[f/2] : box_lo_ff[f/2];
   endfunction

   // ---------------- pipeline control ----------------
   logic v_a_ff, v_b_ff, v_h_ff, v_s_ff, v_m_ff, v_o_ff;
   logic v_dv_ff [QW+1];
   logic rdy_a, rdy_b, rdy_h, rdy_s, rdy_m, rdy_o;
   logic rdy_dv [QW+1];

   assign rdy_o = !v_o_ff || !rsp_stall;
   assign rdy_m = !v_m_ff || rdy_o;
   assign rdy_s = !v_s_ff || rdy_m;
   assign rdy_h = !v_h_ff || rdy_s;
   assign rdy_dv[QW] = !v_dv_ff[QW] || rdy_h;
   for (genvar j = 0; j < QW; j++) begin : g_rdy
      assign rdy_dv[j] = !v_dv_ff[j] || rdy_dv[j+1];
   end
   assign rdy_b = !v_b_ff || rdy_dv[0];
   assign rdy_a = !v_a_ff || rdy_b;
   assign req_stall = !rdy_a;

   // ---------------- stage A: face offsets ----------------
   req_type               rq_a_ff;
   logic signed [CW:0]    diff_a_ff [6];

   always_ff @(posedge clock) begin
      if (reset) v_a_ff <= 1'b0;
      else if (rdy_a) v_a_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         rq_a_ff <= req_data;
         for (int f = 0; f < 6; f++) begin
            diff_a_ff[f] <= (CW+1)'(face_c(f)) - (CW+1)'(org(req_data, f/2));
         end
      end
   end

   // ---------------- stage B: numerator products ----------------
   req_type  rq_b_ff;
   prod_type pr_b_ff [6][2];

   always_ff @(posedge clock) begin
      if (reset) v_b_ff <= 1'b0;
      else if (rdy_b) v_b_ff <= v_a_ff;
   end

   always_ff @(posedge clock) begin
      logic [CW:0]   dm;
      coord_type     dk;
      coord_type     da;
      if (rdy_b) begin
         rq_b_ff <= rq_a_ff;
         for (int f = 0; f < 6; f++) begin
            dm = diff_a_ff[f][CW] ? (~diff_a_ff[f] + 1'b1) : diff_a_ff[f];
            da = hdg(rq_a_ff, f/2);
            for (int j = 0; j < 2; j++) begin
               dk = hdg(rq_a_ff, (f/2 + 1 + j) % 3);
               pr_b_ff[f][j].prod <= dm[CW-1:0] * cmag(dk);
               pr_b_ff[f][j].neg  <= diff_a_ff[f][CW] ^ dk[CW-1] ^ da[CW-1];
               pr_b_ff[f][j].dmag <= cmag(da);
            end
         end
      end
   end

   // ---------------- divider: range check, then one bit per stage ----------------
   req_type rq_dv_ff [QW+1];
   div_type dv_ff [QW+1][6][2];

   always_ff @(posedge clock) begin
      if (reset) v_dv_ff[0] <= 1'b0;
      else if (rdy_dv[0]) v_dv_ff[0] <= v_b_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy_dv[0]) begin
         rq_dv_ff[0] <= rq_b_ff;
         for (int f = 0; f < 6; f++) begin
            for (int j = 0; j < 2; j++) begin
               // a quotient that needs more than QW bits is out of any box
               dv_ff[0][f][j].ovf  <= {2'b00, pr_b_ff[f][j].prod}
                                   >= {pr_b_ff[f][j].dmag, {QW{1'b0}}};
               dv_ff[0][f][j].neg  <= pr_b_ff[f][j].neg;
               dv_ff[0][f][j].dmag <= pr_b_ff[f][j].dmag;
               dv_ff[0][f][j].rem  <= CW'(pr_b_ff[f][j].prod[PW-1:QW]);
               dv_ff[0][f][j].num  <= pr_b_ff[f][j].prod[QW-1:0];
               dv_ff[0][f][j].quo  <= '0;
            end
         end
      end
   end

   for (genvar s = 1; s <= QW; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) v_dv_ff[s] <= 1'b0;
         else if (rdy_dv[s]) v_dv_ff[s] <= v_dv_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (rdy_dv[s]) begin
            rq_dv_ff[s] <= rq_dv_ff[s-1];
            for (int f = 0; f < 6; f++) begin
               for (int j = 0; j < 2; j++) begin
                  dv_ff[s][f][j] <= div_step(dv_ff[s-1][f][j]);
               end
            end
         end
      end
   end

   // ---------------- stage H: crossing points and bounds test ----------------
   req_type   rq_h_ff;
   logic      hit_h_ff [6];
   coord_type pt_h_ff [6][3];

   always_ff @(posedge clock) begin
      if (reset) v_h_ff <= 1'b0;
      else if (rdy_h) v_h_ff <= v_dv_ff[QW];
   end

   always_ff @(posedge clock) begin
      logic signed [QW:0]   q;
      logic signed [VW-1:0] v;
      logic signed [VW-1:0] lo;
      logic signed [VW-1:0] hi;
      logic                 ok;
      int                   k;
      if (rdy_h) begin
         rq_h_ff <= rq_dv_ff[QW];
         for (int f = 0; f < 6; f++) begin
            ok = hdg(rq_dv_ff[QW], f/2) != '0;
            pt_h_ff[f][f/2] <= face_c(f);
            for (int j = 0; j < 2; j++) begin
               k  = (f/2 + 1 + j) % 3;
               q  = dv_ff[QW][f][j].neg ? -$signed({1'b0, dv_ff[QW][f][j].quo})
                                       :  $signed({1'b0, dv_ff[QW][f][j].quo});
               v  = VW'(org(rq_dv_ff[QW], k)) + VW'(q);
               lo = VW'(box_lo_ff[k]);
               hi = VW'(box_hi_ff[k]);
               ok = ok && !dv_ff[QW][f][j].ovf && (v >= lo) && (v <= hi);
               pt_h_ff[f][k] <= v[CW-1:0];
            end
            hit_h_ff[f] <= ok;
         end
      end
   end

   // ---------------- stage S: keep the first two hits ----------------
   req_type   rq_s_ff;
   coord_type kp_s_ff [2][3];
   logic      kv_s_ff [2];
   logic      xs_s_ff;

   always_ff @(posedge clock) begin
      if (reset) v_s_ff <= 1'b0;
      else if (rdy_s) v_s_ff <= v_h_ff;
   end

   always_ff @(posedge clock) begin
      logic [2:0] cnt;
      coord_type  k0 [3];
      coord_type  k1 [3];
      if (rdy_s) begin
         cnt = '0;
         for (int k = 0; k < 3; k++) begin
            k0[k] = '0;
            k1[k] = '0;
         end
         for (int f = 0; f < 6; f++) begin
            if (hit_h_ff[f]) begin
               if (cnt == 3'd0) k0 = pt_h_ff[f];
               else if (cnt == 3'd1) k1 = pt_h_ff[f];
               cnt = cnt + 3'd1;
            end
         end
         rq_s_ff    <= rq_h_ff;
         kp_s_ff[0] <= k0;
         kp_s_ff[1] <= k1;
         kv_s_ff[0] <= cnt >= 3'd1;
         kv_s_ff[1] <= cnt >= 3'd2;
         xs_s_ff    <= cnt > 3'd2;
      end
   end

   // ---------------- stage M: dot product terms ----------------
   coord_type            kp_m_ff [2][3];
   logic                 kv_m_ff [2];
   logic                 xs_m_ff;
   logic signed [PW:0]   tm_m_ff [2][3];

   always_ff @(posedge clock) begin
      if (reset) v_m_ff <= 1'b0;
      else if (rdy_m) v_m_ff <= v_s_ff;
   end

   always_ff @(posedge clock) begin
      logic signed [CW:0] dp;
      if (rdy_m) begin
         kp_m_ff <= kp_s_ff;
         kv_m_ff <= kv_s_ff;
         xs_m_ff <= xs_s_ff;
         for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < 3; k++) begin
               dp = (CW+1)'(kp_s_ff[i][k]) - (CW+1)'(org(rq_s_ff, k));
               tm_m_ff[i][k] <= (PW+1)'(dp * hdg(rq_s_ff, k));
            end
         end
      end
   end

   // ---------------- stage O: classify and register the result ----------------
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) v_o_ff <= 1'b0;
      else if (rdy_o) v_o_ff <= v_m_ff;
   end

   always_ff @(posedge clock) begin
      logic signed [DW-1:0] dot;
      logic                 fw [2];
      logic                 bk [2];
      if (rdy_o) begin
         for (int i = 0; i < 2; i++) begin
            dot   = DW'(tm_m_ff[i][0]) + DW'(tm_m_ff[i][1]) + DW'(tm_m_ff[i][2]);
            fw[i] = kv_m_ff[i] && (dot > 0);
            bk[i] = kv_m_ff[i] && !(dot > 0);
         end
         // the second kept hit overwrites the first of the same class
         rsp_ff.fwd_x  <= fw[1] ? kp_m_ff[1][0] : (fw[0] ? kp_m_ff[0][0] : '0);
         rsp_ff.fwd_y  <= fw[1] ? kp_m_ff[1][1] : (fw[0] ? kp_m_ff[0][1] : '0);
         rsp_ff.fwd_z  <= fw[1] ? kp_m_ff[1][2] : (fw[0] ? kp_m_ff[0][2] : '0);
         rsp_ff.back_x <= bk[1] ? kp_m_ff[1][0] : (bk[0] ? kp_m_ff[0][0] : '0);
         rsp_ff.back_y <= bk[1] ? kp_m_ff[1][1] : (bk[0] ? kp_m_ff[0][1] : '0);
         rsp_ff.back_z <= bk[1] ? kp_m_ff[1][2] : (bk[0] ? kp_m_ff[0][2] : '0);
         rsp_ff.hit_mask    <= {bk[0] || bk[1], fw[0] || fw[1]};
         rsp_ff.excess_hits <= xs_m_ff;
      end
   end

   assign rsp_valid = v_o_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- assertions ----------------
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output was free");

   a_excess_has_hits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.excess_hits) |-> (rsp_data.hit_mask != 2'b00))
      else $error("excess hits flagged without any kept hit");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
